// ===== design/slru_pkg.sv =====
// Package for the set-associative LRU write-back cache.
// It holds shared constants, result codes, the control state type and the update result type.
// No dependencies.
`default_nettype none
package slru_pkg;

	localparam int NUM_SETS_DEF = 256;
	localparam int NUM_WAYS_DEF = 4;
	localparam int KEY_BITS_DEF = 32;

	localparam int IN_KEY_W   = 32;
	localparam int OUT_SET_W  = 8;
	localparam int OUT_WAY_W  = 2;
	localparam int OUT_KEY_W  = 32;
	localparam int CNT_W      = 32;
	localparam int STATUS_W   = 2;

	localparam logic [STATUS_W-1:0] STATUS_HIT       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FILLED    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FETCH_ERR = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_UPD
	} slru_state_t;

	typedef struct packed {
		logic hit;
		logic filled;
		logic wb;
	} slru_upd_t;

endpackage
`default_nettype wire

// ===== design/slru_req_if.sv =====
// Request channel of the cache: valid/ready handshake and request fields.
// Depends on slru_pkg for field widths.
`default_nettype none
interface slru_req_if;
	logic                            valid;
	logic                            ready;
	logic [slru_pkg::IN_KEY_W-1:0]   lookup_key;
	logic                            fetch_ok;
	logic                            mark_modified;

	modport source (output valid, lookup_key, fetch_ok, mark_modified, input ready);
	modport sink   (input valid, lookup_key, fetch_ok, mark_modified, output ready);
endinterface
`default_nettype wire

// ===== design/slru_rsp_if.sv =====
// Response channel of the cache: valid/ready handshake and result fields.
// Depends on slru_pkg for field widths.
`default_nettype none
interface slru_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [slru_pkg::STATUS_W-1:0]   status;
	logic [slru_pkg::OUT_SET_W-1:0]  set_index;
	logic [slru_pkg::OUT_WAY_W-1:0]  way_index;
	logic                            writeback;
	logic [slru_pkg::OUT_KEY_W-1:0]  writeback_key;
	logic [slru_pkg::CNT_W-1:0]      hit_total;
	logic [slru_pkg::CNT_W-1:0]      miss_total;
	logic [slru_pkg::CNT_W-1:0]      writeback_total;

	modport source (output valid, status, set_index, way_index, writeback, writeback_key,
		hit_total, miss_total, writeback_total, input ready);
	modport sink   (input valid, status, set_index, way_index, writeback, writeback_key,
		hit_total, miss_total, writeback_total, output ready);
endinterface
`default_nettype wire

// ===== design/set_assoc_lru_writeback_cache.sv =====
// Top level of the set-associative LRU write-back cache tag engine.
// Depends on slru_pkg, slru_req_if, slru_rsp_if, slru_setsel, slru_tagmem, slru_update.
`default_nettype none
// The cache handles one request transaction at a time. A request is taken
// when req.valid and req.ready are both high; its set is the key modulo
// NUM_SETS. When NUM_SETS is a power of two the set row is read from the
// tag memory in the accept cycle and the row is updated and the response
// registered in ST_UPD once the output register is free; otherwise a
// remainder unit that handles one key byte per cycle runs in ST_DIV and
// the row is read in ST_READ before the update.
// The response sits in an output register, so a new request can be accepted
// while the previous response waits for rsp.ready. After reset the tag
// memory is swept clear, one set per cycle, and req.ready stays low until
// the sweep ends. Hit, miss and writeback totals wrap at 2^32.
module set_assoc_lru_writeback_cache #(
	parameter int NUM_SETS = slru_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS = slru_pkg::NUM_WAYS_DEF,
	parameter int KEY_BITS = slru_pkg::KEY_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	slru_req_if.sink     req,
	slru_rsp_if.source   rsp
);
	localparam int  SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int  AGE_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int  FILL_W   = $clog2(NUM_WAYS + 1);
	localparam int  WAY_BITS = KEY_BITS + 2 + AGE_W;
	localparam int  ROW_W    = NUM_WAYS * WAY_BITS + FILL_W;
	localparam bit  IS_POW2  = ((NUM_SETS & (NUM_SETS - 1)) == 0);

	slru_pkg::slru_state_t state_q, state_d;

	logic [KEY_BITS-1:0] in_key;
	logic [KEY_BITS-1:0] key_q;
	logic                fetch_q;
	logic                mark_q;
	logic [SET_W-1:0]    set_q;
	logic [SET_W-1:0]    set_rem;
	logic                set_done;
	logic                accept;
	logic                out_free;
	logic                proceed;
	logic                clr_busy;
	logic [SET_W-1:0]    rd_addr;
	logic [ROW_W-1:0]    rd_row;
	logic [ROW_W-1:0]    new_row;
	logic                do_write;
	logic [AGE_W-1:0]    way;
	logic [KEY_BITS-1:0] wb_key;
	slru_pkg::slru_upd_t res;

	// Keys are taken modulo 2^KEY_BITS.
	assign in_key = KEY_BITS'(64'(req.lookup_key));
	assign accept = req.valid && req.ready;

	slru_setsel #(.NUM_SETS(NUM_SETS), .KEY_BITS(KEY_BITS)) u_setsel (
		.clk(clk), .arst_n(arst_n), .start(accept), .key(in_key),
		.rem(set_rem), .done(set_done)
	);

	slru_tagmem #(.NUM_SETS(NUM_SETS), .ROW_W(ROW_W)) u_tagmem (
		.clk(clk), .arst_n(arst_n), .rd_addr(rd_addr), .rd_data(rd_row),
		.wr_en(proceed && do_write), .wr_addr(set_q), .wr_data(new_row),
		.clr_busy(clr_busy)
	);

	slru_update #(.NUM_WAYS(NUM_WAYS), .KEY_BITS(KEY_BITS)) u_update (
		.row(rd_row), .key(key_q), .fetch_ok(fetch_q), .mark(mark_q),
		.new_row(new_row), .do_write(do_write), .way(way), .wb_key(wb_key), .res(res)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			slru_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = IS_POW2 ? slru_pkg::ST_UPD : slru_pkg::ST_DIV;
				end
			end
			slru_pkg::ST_DIV: begin
				if (set_done) begin
					state_d = slru_pkg::ST_READ;
				end
			end
			slru_pkg::ST_READ: state_d = slru_pkg::ST_UPD;
			slru_pkg::ST_UPD: begin
				if (out_free) begin
					state_d = slru_pkg::ST_IDLE;
				end
			end
			default: state_d = slru_pkg::ST_IDLE;
		endcase
	end

	// Control outputs of the state machine.
	always_comb begin
		req.ready = 1'b0;
		proceed   = 1'b0;
		rd_addr   = set_q;
		case (state_q)
			slru_pkg::ST_IDLE: begin
				req.ready = !clr_busy;
				rd_addr   = set_rem;
			end
			slru_pkg::ST_UPD: proceed = out_free;
			default: begin
			end
		endcase
	end

	assign out_free = !rsp.valid || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= slru_pkg::ST_IDLE;
			rsp.valid           <= 1'b0;
			rsp.hit_total       <= '0;
			rsp.miss_total      <= '0;
			rsp.writeback_total <= '0;
		end else begin
			state_q <= state_d;
			if (proceed) begin
				rsp.valid <= 1'b1;
				if (res.hit) begin
					rsp.hit_total <= rsp.hit_total + slru_pkg::CNT_W'(1);
				end else begin
					rsp.miss_total <= rsp.miss_total + slru_pkg::CNT_W'(1);
				end
				if (res.wb) begin
					rsp.writeback_total <= rsp.writeback_total + slru_pkg::CNT_W'(1);
				end
			end else if (rsp.ready) begin
				rsp.valid <= 1'b0;
			end
		end
	end

	// Request capture and response payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q   <= in_key;
			fetch_q <= req.fetch_ok;
			mark_q  <= req.mark_modified;
		end
		if ((accept && IS_POW2) || (state_q == slru_pkg::ST_DIV && set_done)) begin
			set_q <= set_rem;
		end
		if (proceed) begin
			if (res.hit) begin
				rsp.status <= slru_pkg::STATUS_HIT;
			end else if (res.filled) begin
				rsp.status <= slru_pkg::STATUS_FILLED;
			end else begin
				rsp.status <= slru_pkg::STATUS_FETCH_ERR;
			end
			rsp.set_index     <= slru_pkg::OUT_SET_W'(set_q);
			rsp.way_index     <= slru_pkg::OUT_WAY_W'(way);
			rsp.writeback     <= res.wb;
			rsp.writeback_key <= slru_pkg::OUT_KEY_W'(64'(wb_key));
		end
	end
endmodule
`default_nettype wire

// ===== design/slru_setsel.sv =====
// Set selection: key modulo the set count.
// A mask when the set count is a power of two, else a remainder unit that takes one
// key byte per cycle and uses a constant reciprocal multiplication.
`default_nettype none
module slru_setsel #(
	parameter int NUM_SETS = slru_pkg::NUM_SETS_DEF,
	parameter int KEY_BITS = slru_pkg::KEY_BITS_DEF,
	localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [KEY_BITS-1:0] key,
	output logic      [SET_W-1:0]    rem,
	output logic                     done
);
	localparam bit IS_POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);

	generate
		if (IS_POW2) begin : g_mask
			assign rem  = key[SET_W-1:0] & SET_W'(NUM_SETS - 1);
			assign done = start;
		end else begin : g_serial
			// One key byte per cycle, most significant first. The partial remainder
			// r becomes t = r * 256 + byte. The quotient of t by the set count is
			// estimated with a constant reciprocal and is low by at most one, so a
			// single compare and subtract finishes each step.
			localparam int NB    = (KEY_BITS + 7) / 8;
			localparam int PAD_W = NB * 8;
			localparam int CW    = $clog2(NB + 1);
			localparam int T_W   = SET_W + 8;
			localparam int SH    = T_W + 1;
			localparam int P_W   = T_W + SH;
			localparam logic [SH-1:0] RECIP = SH'((64'd1 << SH) / NUM_SETS);
			logic [PAD_W-1:0] shift_q;
			logic [SET_W-1:0] rem_q;
			logic [CW-1:0]    cnt_q;
			logic             busy_q;
			logic             done_q;
			logic [T_W-1:0]   t_val;
			logic [T_W-1:0]   q_est;
			logic [T_W-1:0]   r_est;
			logic [P_W-1:0]   prod;

			assign t_val = {rem_q, shift_q[PAD_W-1 -: 8]};
			assign prod  = P_W'(t_val) * P_W'(RECIP);
			assign q_est = T_W'(prod >> SH);
			assign r_est = t_val - q_est * T_W'(NUM_SETS);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					done_q <= busy_q && (cnt_q == CW'(1));
					if (start) begin
						busy_q <= 1'b1;
						cnt_q  <= CW'(NB);
					end else if (busy_q) begin
						cnt_q <= cnt_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							busy_q <= 1'b0;
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					shift_q <= PAD_W'(key);
					rem_q   <= '0;
				end else if (busy_q) begin
					shift_q <= shift_q << 8;
					if (r_est >= T_W'(NUM_SETS)) begin
						rem_q <= SET_W'(r_est - T_W'(NUM_SETS));
					end else begin
						rem_q <= SET_W'(r_est);
					end
				end
			end

			assign rem  = rem_q;
			assign done = done_q;
		end
	endgenerate
endmodule
`default_nettype wire

// ===== design/slru_tagmem.sv =====
// Tag memory: one row per set holding every way's key, valid, dirty and age
// plus the set fill count. Registered read; cleared by a sweep after reset.
`default_nettype none
module slru_tagmem #(
	parameter int NUM_SETS = slru_pkg::NUM_SETS_DEF,
	parameter int ROW_W    = 8,
	localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [SET_W-1:0] rd_addr,
	output logic      [ROW_W-1:0] rd_data,
	input  wire logic             wr_en,
	input  wire logic [SET_W-1:0] wr_addr,
	input  wire logic [ROW_W-1:0] wr_data,
	output logic                  clr_busy
);
	logic [ROW_W-1:0] mem [NUM_SETS];
	logic [SET_W-1:0] clr_idx_q;
	logic             clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + SET_W'(1);
			if (clr_idx_q == SET_W'(NUM_SETS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

	assign clr_busy = clr_busy_q;
endmodule
`default_nettype wire

// ===== design/slru_update.sv =====
// Lookup and replacement logic for one set row: hit search, free-way or LRU
// victim choice, age update and the new row. Depends on slru_pkg.
`default_nettype none
module slru_update #(
	parameter int NUM_WAYS = slru_pkg::NUM_WAYS_DEF,
	parameter int KEY_BITS = slru_pkg::KEY_BITS_DEF,
	localparam int AGE_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1,
	localparam int FILL_W  = $clog2(NUM_WAYS + 1),
	localparam int WAY_BITS = KEY_BITS + 2 + AGE_W,
	localparam int ROW_W   = NUM_WAYS * WAY_BITS + FILL_W
) (
	input  wire logic [ROW_W-1:0]    row,
	input  wire logic [KEY_BITS-1:0] key,
	input  wire logic                fetch_ok,
	input  wire logic                mark,
	output logic      [ROW_W-1:0]    new_row,
	output logic                     do_write,
	output logic      [AGE_W-1:0]    way,
	output logic      [KEY_BITS-1:0] wb_key,
	output slru_pkg::slru_upd_t      res
);
	logic [KEY_BITS-1:0] keys   [NUM_WAYS];
	logic                vld    [NUM_WAYS];
	logic                drt    [NUM_WAYS];
	logic [AGE_W-1:0]    age    [NUM_WAYS];
	logic [KEY_BITS-1:0] n_keys [NUM_WAYS];
	logic                n_vld  [NUM_WAYS];
	logic                n_drt  [NUM_WAYS];
	logic [AGE_W-1:0]    n_age  [NUM_WAYS];
	logic [FILL_W-1:0]   fill;
	logic [FILL_W-1:0]   n_fill;

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			keys[w] = row[w*WAY_BITS +: KEY_BITS];
			vld[w]  = row[w*WAY_BITS + KEY_BITS];
			drt[w]  = row[w*WAY_BITS + KEY_BITS + 1];
			age[w]  = row[w*WAY_BITS + KEY_BITS + 2 +: AGE_W];
		end
		fill = row[ROW_W-1 -: FILL_W];
	end

	logic             hit, found;
	logic [AGE_W-1:0] hway, fway, vway, best, tgt;
	logic [FILL_W-1:0] old_age;

	always_comb begin
		hit = 1'b0; hway = '0;
		found = 1'b0; fway = '0;
		best = '0; vway = '0;
		// Descending scans leave the lowest matching way.
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (vld[w] && keys[w] == key) begin
				hit  = 1'b1;
				hway = AGE_W'(w);
			end
			if (!vld[w]) begin
				found = 1'b1;
				fway  = AGE_W'(w);
			end
		end
		// Oldest way; on equal ages the highest way wins.
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (age[w] >= best) begin
				best = age[w];
				vway = AGE_W'(w);
			end
		end
		tgt = hit ? hway : (found ? fway : vway);
		old_age = hit ? FILL_W'(age[hway]) : (found ? fill : FILL_W'(best));
	end

	always_comb begin
		do_write = hit || fetch_ok;
		n_fill   = fill;
		for (int w = 0; w < NUM_WAYS; w++) begin
			n_keys[w] = keys[w];
			n_vld[w]  = vld[w];
			n_drt[w]  = drt[w];
			n_age[w]  = age[w];
			if (AGE_W'(w) != tgt && vld[w] && FILL_W'(age[w]) < old_age) begin
				n_age[w] = age[w] + AGE_W'(1);
			end
		end
		n_age[tgt] = '0;
		if (hit) begin
			n_drt[tgt] = drt[tgt] | mark;
		end else begin
			n_keys[tgt] = key;
			n_vld[tgt]  = 1'b1;
			n_drt[tgt]  = mark;
			if (found && fill < FILL_W'(NUM_WAYS)) begin
				n_fill = fill + FILL_W'(1);
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			new_row[w*WAY_BITS +: KEY_BITS]          = n_keys[w];
			new_row[w*WAY_BITS + KEY_BITS]           = n_vld[w];
			new_row[w*WAY_BITS + KEY_BITS + 1]       = n_drt[w];
			new_row[w*WAY_BITS + KEY_BITS + 2 +: AGE_W] = n_age[w];
		end
		new_row[ROW_W-1 -: FILL_W] = n_fill;

		res.hit    = hit;
		res.filled = !hit && fetch_ok;
		res.wb     = !hit && fetch_ok && !found && drt[vway];
		way        = do_write ? tgt : '0;
		wb_key     = res.wb ? keys[vway] : '0;
	end
endmodule
`default_nettype wire

// ===== tb/sv/tb_cache_pkg.sv =====
// Testbench-side types for the cache tag engine checks.
// Depends on slru_pkg for field widths and result codes.
`default_nettype none
package tb_cache_pkg;

	typedef struct packed {
		logic [slru_pkg::STATUS_W-1:0]  status;
		logic [slru_pkg::OUT_SET_W-1:0] set_index;
		logic [slru_pkg::OUT_WAY_W-1:0] way_index;
		logic                           writeback;
		logic [slru_pkg::OUT_KEY_W-1:0] writeback_key;
		logic [slru_pkg::CNT_W-1:0]     hit_total;
		logic [slru_pkg::CNT_W-1:0]     miss_total;
		logic [slru_pkg::CNT_W-1:0]     writeback_total;
	} cache_result_t;
endpackage
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the set-associative LRU write-back cache.
// Depends on slru_pkg, tb_cache_pkg, slru_req_if, slru_rsp_if and the cache RTL.
`default_nettype none
module tb_top;

	localparam int SETS = slru_pkg::NUM_SETS_DEF;
	localparam int WAYS = slru_pkg::NUM_WAYS_DEF;
	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	slru_req_if req ();
	slru_rsp_if rsp ();

	set_assoc_lru_writeback_cache dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// Shadow of the tag store. Keys are only compared for valid ways, so the
	// stale contents of never-filled ways do not matter.
	logic [slru_pkg::IN_KEY_W-1:0] shadow_key [SETS][WAYS];
	logic                          shadow_valid [SETS][WAYS];
	logic                          shadow_dirty [SETS][WAYS];
	int unsigned                   shadow_age [SETS][WAYS];
	int unsigned                   shadow_fill [SETS];
	logic [slru_pkg::CNT_W-1:0]    hits_so_far, misses_so_far, writebacks_so_far;

	tb_cache_pkg::cache_result_t pending_results[$];
	int errors = 0;
	int results_seen = 0;
	int hits_checked = 0, fills_checked = 0, failed_checked = 0, evicts_checked = 0;
	int quiet_cycles = 0;

	// Ways younger than old_age grow one step older; the touched way becomes newest.
	function automatic void make_newest(int s, int w, int unsigned old_age);
		for (int i = 0; i < WAYS; i++) begin
			if (i != w && shadow_valid[s][i] && shadow_age[s][i] < old_age)
				shadow_age[s][i]++;
		end
		shadow_age[s][w] = 0;
	endfunction

	// Predicts the outcome of one lookup and updates the shadow state.
	function automatic tb_cache_pkg::cache_result_t lookup_outcome(
		logic [slru_pkg::IN_KEY_W-1:0] key, logic ok, logic mark);
		tb_cache_pkg::cache_result_t r;
		int s;
		int way;
		bit found;
		bit free_way;
		int unsigned oldest;
		r = '0;
		s = key % SETS;
		way = 0;
		found = 0;
		r.set_index = s[slru_pkg::OUT_SET_W-1:0];
		for (int i = 0; i < WAYS; i++) begin
			if (!found && shadow_valid[s][i] && shadow_key[s][i] == key) begin
				found = 1;
				way = i;
			end
		end
		if (found) begin
			hits_so_far++;
			make_newest(s, way, shadow_age[s][way]);
			shadow_dirty[s][way] |= mark;
			r.status = slru_pkg::STATUS_HIT;
		end else begin
			misses_so_far++;
			if (!ok) begin
				r.status = slru_pkg::STATUS_FETCH_ERR;
			end else begin
				free_way = 0;
				for (int i = 0; i < WAYS; i++) begin
					if (!free_way && !shadow_valid[s][i]) begin
						free_way = 1;
						way = i;
					end
				end
				if (free_way) begin
					oldest = shadow_fill[s];
					if (shadow_fill[s] < WAYS)
						shadow_fill[s]++;
				end else begin
					// Ties go to the highest way, matching the >= scan.
					oldest = 0;
					for (int i = 0; i < WAYS; i++) begin
						if (shadow_age[s][i] >= oldest) begin
							oldest = shadow_age[s][i];
							way = i;
						end
					end
					if (shadow_dirty[s][way]) begin
						r.writeback = 1'b1;
						r.writeback_key = shadow_key[s][way];
						writebacks_so_far++;
					end
				end
				shadow_key[s][way] = key;
				shadow_valid[s][way] = 1'b1;
				shadow_dirty[s][way] = mark;
				make_newest(s, way, oldest);
				r.status = slru_pkg::STATUS_FILLED;
			end
		end
		r.way_index = way[slru_pkg::OUT_WAY_W-1:0];
		r.hit_total = hits_so_far;
		r.miss_total = misses_so_far;
		r.writeback_total = writebacks_so_far;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %0h, expected %0h (result %0d)", what, got, want,
			results_seen);
	endtask

	// Sends one lookup transaction after a random gap, predicting it on acceptance.
	// Valid stays high when the next transaction follows with no gap.
	task automatic send_lookup(logic [slru_pkg::IN_KEY_W-1:0] key, logic ok, logic mark);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.lookup_key <= key;
		req.fetch_ok <= ok;
		req.mark_modified <= mark;
		do @(posedge clk); while (!req.ready);
		pending_results.push_back(lookup_outcome(key, ok, mark));
	endtask

	// Keys that share one set, so that sets fill and evict often.
	function automatic logic [slru_pkg::IN_KEY_W-1:0] key_in_set(int s, int tag);
		return slru_pkg::IN_KEY_W'(tag) * SETS + slru_pkg::IN_KEY_W'(s);
	endfunction

	// Pauses the sender until the response queue has drained.
	task automatic drain_responses();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Field extremes, both hit and miss paths, and the special cases.
	task automatic test_directed();
		send_lookup(32'h0000_0000, 1'b1, 1'b0);      // fill way 0 of set 0
		send_lookup(32'h0000_0000, 1'b0, 1'b1);      // hit, marks modified
		send_lookup(32'hFFFF_FFFF, 1'b0, 1'b1);      // fetch failed, mark ignored
		send_lookup(32'hFFFF_FFFF, 1'b1, 1'b1);      // fill of set 255, starts modified
		send_lookup(32'hFFFF_FFFF, 1'b1, 1'b0);      // hit, mark stays
		for (int t = 1; t <= 4; t++)                 // fills set 0, then evicts key 0
			send_lookup(key_in_set(0, t), 1'b1, t[0]);
		send_lookup(key_in_set(0, 2), 1'b1, 1'b1);   // hit in the middle of the order
		send_lookup(32'h0000_0000, 1'b1, 1'b0);      // miss, evicts a modified entry
		send_lookup(key_in_set(0, 9), 1'b0, 1'b0);   // full set, fetch failed
		send_lookup(32'hAAAA_AA55, 1'b1, 1'b1);
		send_lookup(32'h5555_55AA, 1'b1, 1'b0);
		// Consecutive hits on one key and set.
		send_lookup(32'hAAAA_AA55, 1'b1, 1'b0);
		send_lookup(32'hAAAA_AA55, 1'b1, 1'b0);
		send_lookup(32'h8000_0080, 1'b1, 1'b1);
		drain_responses();
	endtask

	// Mostly lookups with a small tag pool, half of them on sets 0 to 3, so hits,
	// fills and writebacks all recur; the rest are fully random keys.
	task automatic test_random(int count);
		int s;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) < 8) begin
				s = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, SETS - 1);
				send_lookup(key_in_set(s, $urandom_range(0, 7)), $urandom_range(0, 7) != 0,
					$urandom_range(0, 1));
			end else begin
				send_lookup($urandom, $urandom_range(0, 1), $urandom_range(0, 1));
			end
			if (n == count / 2)
				drain_responses();
		end
	endtask

	// Checks each accepted response against the oldest prediction.
	always @(posedge clk) begin
		tb_cache_pkg::cache_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected response", 32'(rsp.status), 32'hx);
			end else begin
				want = pending_results.pop_front();
				case (want.status)
					slru_pkg::STATUS_HIT: hits_checked++;
					slru_pkg::STATUS_FILLED: fills_checked++;
					default: failed_checked++;
				endcase
				if (want.writeback)
					evicts_checked++;
				if (rsp.status !== want.status)
					report_mismatch("status", 32'(rsp.status), 32'(want.status));
				if (rsp.set_index !== want.set_index)
					report_mismatch("set_index", 32'(rsp.set_index), 32'(want.set_index));
				if (rsp.way_index !== want.way_index)
					report_mismatch("way_index", 32'(rsp.way_index), 32'(want.way_index));
				if (rsp.writeback !== want.writeback)
					report_mismatch("writeback", 32'(rsp.writeback), 32'(want.writeback));
				if (rsp.writeback_key !== want.writeback_key)
					report_mismatch("writeback_key", rsp.writeback_key, want.writeback_key);
				if (rsp.hit_total !== want.hit_total)
					report_mismatch("hit_total", rsp.hit_total, want.hit_total);
				if (rsp.miss_total !== want.miss_total)
					report_mismatch("miss_total", rsp.miss_total, want.miss_total);
				if (rsp.writeback_total !== want.writeback_total)
					report_mismatch("writeback_total", rsp.writeback_total,
						want.writeback_total);
			end
		end
	end

	// The receiver draws a stall length per response; some stretches never stall.
	initial begin
		int hold;
		forever begin
			hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			if (hold > 0) begin
				rsp.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	// Watchdog: the post-reset sweep ends well before the limit.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout with %0d responses outstanding", pending_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		req.valid <= 1'b0;
		req.lookup_key <= '0;
		req.fetch_ok <= 1'b0;
		req.mark_modified <= 1'b0;
		hits_so_far = '0;
		misses_so_far = '0;
		writebacks_so_far = '0;
		for (int s = 0; s < SETS; s++) begin
			shadow_fill[s] = 0;
			for (int w = 0; w < WAYS; w++) begin
				shadow_key[s][w] = '0;
				shadow_valid[s][w] = 1'b0;
				shadow_dirty[s][w] = 1'b0;
				shadow_age[s][w] = 0;
			end
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(936);

		drain_responses();
		repeat (20) @(posedge clk);
		$display("Checked %0d lookups: %0d hits, %0d fills, %0d failed fetches,",
			results_seen, hits_checked, fills_checked, failed_checked);
		$display("and %0d writebacks of evicted modified entries.", evicts_checked);
		if (errors == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
